>>> src/cae_pkg.sv
// ---------------------------------------------------------------------------
// cae_pkg: shared types and constants of the circular arc point evaluator
// Word layouts, angle constants, the arctangent table and the rounding function.
// ---------------------------------------------------------------------------
package cae_pkg;

	localparam int RED_CELLS = 38;
	localparam int DIV_CELLS = 44;

	localparam logic [1:0] REG_SPEED = 2'd0;
	localparam logic [1:0] REG_CURV  = 2'd1;
	localparam logic [1:0] REG_EXPL  = 2'd2;

	localparam logic [59:0] TWO_PI_Q56 = 60'h6487ED5110B4612;
	localparam logic signed [47:0] PI_Q40      = 48'sh3243F6A8886;
	localparam logic signed [47:0] HALF_PI_Q40 = 48'sh1921FB54443;
	localparam logic signed [47:0] QUARTER_PI_Q40 = 48'shC90FDAA221;
	localparam logic signed [47:0] TWO_PI_Q40  = 48'sh6487ED5110C;
	localparam logic signed [47:0] GAIN_Q40    = 48'sh9B74EDA800;
	localparam logic signed [47:0] ONE_Q40     = 48'sh10000000000;

	typedef struct packed {
		logic signed [31:0] param_t;
		logic [1:0]         deriv_order;
	} item_t;

	typedef struct packed {
		logic signed [47:0] coord_x;
		logic signed [47:0] coord_y;
		logic [1:0]         deriv_index;
		logic               last_result;
		logic               saturated;
	} result_t;

	typedef struct packed {
		logic [1:0]         ord;
		logic               line;
		logic               neg;
		logic signed [31:0] d;
		logic [31:0]        ad;
		logic [31:0]        k;
		logic [95:0]        kdd;
		logic signed [47:0] line_x;
	} side_t;

	typedef struct packed {
		logic [59:0] r;
		logic [RED_CELLS-1:0] rest;
		side_t       side;
	} red_t;

	typedef struct packed {
		logic signed [47:0] x;
		logic signed [47:0] y;
		logic signed [47:0] z;
		logic               flip;
		side_t              side;
	} cor_t;

	typedef struct packed {
		logic [1:0]         ord;
		logic               line;
		logic signed [47:0] line_x;
		logic signed [31:0] d;
		logic [31:0]        k;
		logic signed [47:0] cx1;
		logic signed [47:0] cy1;
		logic signed [47:0] cx2;
		logic signed [47:0] cy2;
		logic               sat1;
		logic               sat2;
		logic               xneg;
		logic               yneg;
	} pass_t;

	typedef struct packed {
		logic [31:0] rx;
		logic [31:0] ry;
		logic [DIV_CELLS-1:0] nx;
		logic [DIV_CELLS-1:0] ny;
		logic [DIV_CELLS-1:0] qx;
		logic [DIV_CELLS-1:0] qy;
		pass_t       p;
	} dv_t;

	// elaboration only: atan(2^-i) in Q.40 from the alternating series
	function automatic logic signed [47:0] atan_q40(input int i);
		logic [63:0] sum;
		logic [63:0] num;
		logic [63:0] q;
		logic [64:0] rem;
		int n;
		int m;
		int b;
		sum = '0;
		if (i == 0) return QUARTER_PI_Q40;
		for (n = 0; i * (2 * n + 1) < 62; n++) begin
			m = 2 * n + 1;
			num = 64'd1 << (62 - i * m);
			rem = '0;
			q = '0;
			for (b = 63; b >= 0; b--) begin
				rem = {rem[63:0], num[b]};
				if (rem >= 65'(m)) begin
					rem = rem - 65'(m);
					q[b] = 1'b1;
				end
			end
			if (n % 2 == 1) sum = sum - q;
			else sum = sum + q;
		end
		return 48'((sum + (64'd1 << 21)) >> 22);
	endfunction

	// round magnitude m / 2^s half up, apply sign, clip to 48 bits
	function automatic logic [48:0] rnd_sat(input logic [127:0] m, input int s,
			input logic neg);
		logic [127:0] v;
		logic [127:0] lim;
		logic         sat;
		v = (m + (128'd1 << (s - 1))) >> s;
		lim = neg ? (128'd1 << 47) : ((128'd1 << 47) - 128'd1);
		sat = 1'b0;
		if (v > lim) begin
			v = lim;
			sat = 1'b1;
		end
		return {sat, neg ? 48'(-v[47:0]) : v[47:0]};
	endfunction

endpackage

>>> src/cae_red_cell.sv
// ---------------------------------------------------------------------------
// cae_red_cell: one restoring step of the angle reduction modulo 2*pi
// Shifts in the next product bit and subtracts 2*pi when it fits.
// ---------------------------------------------------------------------------
module cae_red_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_v,
	input  cae_pkg::red_t   in_d,
	output logic            out_v,
	output cae_pkg::red_t   out_d
);
	import cae_pkg::*;

	red_t        nxt;
	logic [59:0] tr;

	always_comb begin
		nxt = in_d;
		tr = {in_d.r[58:0], in_d.rest[RED_CELLS-1]};
		nxt.r = (tr >= TWO_PI_Q56) ? tr - TWO_PI_Q56 : tr;
		nxt.rest = in_d.rest << 1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v <= 1'b0;
		end else if (en) begin
			out_v <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_d <= nxt;
		end
	end

endmodule

>>> src/cae_cordic_cell.sv
// ---------------------------------------------------------------------------
// cae_cordic_cell: one rotation-mode CORDIC micro-rotation
// Rotates by +/- atan(2^-IDX) toward zero residual angle.
// ---------------------------------------------------------------------------
module cae_cordic_cell #(
	parameter int IDX = 0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_v,
	input  cae_pkg::cor_t   in_d,
	output logic            out_v,
	output cae_pkg::cor_t   out_d
);
	import cae_pkg::*;

	localparam logic signed [47:0] ATAN = atan_q40(IDX);

	cor_t               nxt;
	logic signed [47:0] dx;
	logic signed [47:0] dy;

	always_comb begin
		nxt = in_d;
		dx = in_d.y >>> IDX;
		dy = in_d.x >>> IDX;
		if (in_d.z >= 0) begin
			nxt.x = in_d.x - dx;
			nxt.y = in_d.y + dy;
			nxt.z = in_d.z - ATAN;
		end else begin
			nxt.x = in_d.x + dx;
			nxt.y = in_d.y - dy;
			nxt.z = in_d.z + ATAN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v <= 1'b0;
		end else if (en) begin
			out_v <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_d <= nxt;
		end
	end

endmodule

>>> src/cae_div_cell.sv
// ---------------------------------------------------------------------------
// cae_div_cell: one restoring division step for both position coordinates
// Produces one quotient bit of x and of y per cell.
// ---------------------------------------------------------------------------
module cae_div_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_v,
	input  cae_pkg::dv_t    in_d,
	output logic            out_v,
	output cae_pkg::dv_t    out_d
);
	import cae_pkg::*;

	dv_t         nxt;
	logic [31:0] tx;
	logic [31:0] ty;
	logic        bx;
	logic        by;

	always_comb begin
		nxt = in_d;
		tx = {in_d.rx[30:0], in_d.nx[DIV_CELLS-1]};
		ty = {in_d.ry[30:0], in_d.ny[DIV_CELLS-1]};
		bx = tx >= in_d.p.k;
		by = ty >= in_d.p.k;
		nxt.rx = bx ? tx - in_d.p.k : tx;
		nxt.ry = by ? ty - in_d.p.k : ty;
		nxt.nx = in_d.nx << 1;
		nxt.ny = in_d.ny << 1;
		nxt.qx = {in_d.qx[DIV_CELLS-2:0], bx};
		nxt.qy = {in_d.qy[DIV_CELLS-2:0], by};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v <= 1'b0;
		end else if (en) begin
			out_v <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_d <= nxt;
		end
	end

endmodule

>>> src/circular_arc_point_evaluator.sv
// ---------------------------------------------------------------------------
// circular_arc_point_evaluator: point and derivatives of a planar arc
// Fixed-point arc evaluation through chains of reduction, CORDIC and
// divider cells.
// ---------------------------------------------------------------------------
// Usage:
//   item_*   : input words (param_t, deriv_order), valid/ready.
//   result_* : result words, valid/ready; one word per derivative up to the
//              requested order, last_result set on the final one.
//   cfg_*    : register writes (speed, curvature, explicit_derivatives);
//              the user must write only while the block is idle (not enforced).
// Path: front registers, reduction, CORDIC, post and divider cells, result register.
// Throughput: one result word per cycle while result_ready is high, through
//   the single result port; the cell chains accept a new word only while no
//   item is held or the held item's last word is being taken.
// Reset clears all pipeline valids and loads the register defaults
//   (speed 1.0, curvature 0, derivatives on).
// A stalled receiver holds the result word and freezes the whole chain;
//   item_ready drops until the held item's last word is taken.
// ---------------------------------------------------------------------------
module circular_arc_point_evaluator #(
	parameter int CORDIC_STAGES  = 24,
	parameter int LINE_THRESHOLD = 168
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  cae_pkg::item_t    item,
	output logic              result_valid,
	input  logic              result_ready,
	output cae_pkg::result_t  result,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [31:0]       cfg_data
);
	import cae_pkg::*;

	logic [31:0] speed_q;
	logic [31:0] curv_q;
	logic        expl_q;
	logic        en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q <= 32'd65536;
			curv_q <= '0;
			expl_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SPEED: speed_q <= cfg_data;
				REG_CURV:  curv_q <= cfg_data;
				REG_EXPL:  expl_q <= cfg_data[0];
				default:   ;
			endcase
		end
	end

	assign item_ready = en;

	// front: operands
	logic               v_s1;
	logic [1:0]         ord_s1;
	logic               line_s1;
	logic               neg_s1;
	logic signed [31:0] d_s1;
	logic [31:0]        k_s1;
	logic [31:0]        ad_s1;
	logic [31:0]        at_s1;
	logic [1:0]         ord_c;

	always_comb begin
		ord_c = (item.deriv_order == 2'd3) ? 2'd2 : item.deriv_order;
		if (!expl_q) ord_c = 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= item_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ord_s1 <= ord_c;
			line_s1 <= $signed(curv_q) < $signed(32'(LINE_THRESHOLD));
			neg_s1 <= speed_q[31] ^ item.param_t[31];
			d_s1 <= $signed(speed_q);
			k_s1 <= curv_q;
			ad_s1 <= speed_q[31] ? 32'(-speed_q) : speed_q;
			at_s1 <= item.param_t[31] ? 32'(-item.param_t) : 32'(item.param_t);
		end
	end

	// front: |d||t| and d^2
	logic        v_s2;
	side_t       sd_s2;
	logic [63:0] pdt_s2;
	logic [63:0] pdd_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd_s2.ord <= ord_s1;
			sd_s2.line <= line_s1;
			sd_s2.neg <= neg_s1;
			sd_s2.d <= d_s1;
			sd_s2.k <= k_s1;
			sd_s2.ad <= ad_s1;
			sd_s2.kdd <= '0;
			sd_s2.line_x <= '0;
			pdt_s2 <= 64'(ad_s1) * 64'(at_s1);
			pdd_s2 <= 64'(ad_s1) * 64'(ad_s1);
		end
	end

	// front: partial products with k, line position
	logic        v_s3;
	side_t       sd_s3;
	side_t       sd_c3;
	logic [63:0] wl_s3;
	logic [63:0] wh_s3;
	logic [63:0] kl_s3;
	logic [63:0] kh_s3;
	logic [47:0] lmag;

	assign lmag = 48'((pdt_s2 + 64'h8000) >> 16);

	always_comb begin
		sd_c3 = sd_s2;
		sd_c3.line_x = sd_s2.neg ? $signed(-lmag) : $signed(lmag);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd_s3 <= sd_c3;
			wl_s3 <= 64'(sd_s2.k) * 64'(pdt_s2[31:0]);
			wh_s3 <= 64'(sd_s2.k) * 64'(pdt_s2[63:32]);
			kl_s3 <= 64'(sd_s2.k) * 64'(pdd_s2[31:0]);
			kh_s3 <= 64'(sd_s2.k) * 64'(pdd_s2[63:32]);
		end
	end

	// front: 96-bit sums, into reduction chain
	logic [95:0] w96;
	red_t        red_c;
	red_t        red_d [0:RED_CELLS];
	logic        red_v [0:RED_CELLS];

	assign w96 = {32'd0, wl_s3} + {wh_s3, 32'd0};

	always_comb begin
		red_c.r = {2'b00, w96[95:RED_CELLS]};
		red_c.rest = w96[RED_CELLS-1:0];
		red_c.side = sd_s3;
		red_c.side.kdd = {32'd0, kl_s3} + {kh_s3, 32'd0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) red_v[0] <= 1'b0;
		else if (en) red_v[0] <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			red_d[0] <= red_c;
		end
	end

	for (genvar j = 0; j < RED_CELLS; j++) begin : g_red
		cae_red_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.in_v   (red_v[j]),
			.in_d   (red_d[j]),
			.out_v  (red_v[j+1]),
			.out_d  (red_d[j+1])
		);
	end

	// angle: sign, rounding to Q.40, fold into [-pi/2, pi/2]
	cor_t               cor_d [0:CORDIC_STAGES];
	logic               cor_v [0:CORDIC_STAGES];
	red_t               rl;
	logic [59:0]        r2;
	logic signed [47:0] a0;
	logic signed [47:0] a1;
	logic signed [47:0] a2;
	logic               fl;

	assign rl = red_d[RED_CELLS];

	always_comb begin
		r2 = (rl.side.neg && rl.r != '0) ? TWO_PI_Q56 - rl.r : rl.r;
		a0 = $signed(48'((r2 + 60'h8000) >> 16));
		a1 = (a0 > PI_Q40) ? a0 - TWO_PI_Q40 : a0;
		fl = 1'b0;
		a2 = a1;
		if (a1 > HALF_PI_Q40) begin
			a2 = a1 - PI_Q40;
			fl = 1'b1;
		end else if (a1 < -HALF_PI_Q40) begin
			a2 = a1 + PI_Q40;
			fl = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cor_v[0] <= 1'b0;
		else if (en) cor_v[0] <= red_v[RED_CELLS];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cor_d[0].x <= GAIN_Q40;
			cor_d[0].y <= '0;
			cor_d[0].z <= a2;
			cor_d[0].flip <= fl;
			cor_d[0].side <= rl.side;
		end
	end

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cor
		cae_cordic_cell #(.IDX(i)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.in_v   (cor_v[i]),
			.in_d   (cor_d[i]),
			.out_v  (cor_v[i+1]),
			.out_d  (cor_d[i+1])
		);
	end

	// post 1: sin/cos, Q.30 magnitudes, dividends
	cor_t               cl;
	logic signed [47:0] sn;
	logic signed [47:0] cs;
	logic signed [47:0] omc;
	logic [47:0]        asn;
	logic [47:0]        acs;
	logic [47:0]        aomc;

	assign cl = cor_d[CORDIC_STAGES];

	always_comb begin
		sn = cl.flip ? -cl.y : cl.y;
		cs = cl.flip ? -cl.x : cl.x;
		omc = ONE_Q40 - cs;
		asn = sn[47] ? 48'(-sn) : 48'(sn);
		acs = cs[47] ? 48'(-cs) : 48'(cs);
		aomc = omc[47] ? 48'(-omc) : 48'(omc);
	end

	logic        v_p1;
	side_t       sd_p1;
	logic [31:0] s30_p1;
	logic [31:0] c30_p1;
	logic [DIV_CELLS-1:0] nx_p1;
	logic [DIV_CELLS-1:0] ny_p1;
	logic        xneg_p1;
	logic        yneg_p1;
	logic        snn_p1;
	logic        snp_p1;
	logic        csn_p1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_p1 <= 1'b0;
		else if (en) v_p1 <= cor_v[CORDIC_STAGES];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd_p1 <= cl.side;
			s30_p1 <= 32'((asn + 48'd512) >> 10);
			c30_p1 <= 32'((acs + 48'd512) >> 10);
			nx_p1 <= DIV_CELLS'(asn) + DIV_CELLS'(cl.side.k >> 1);
			ny_p1 <= DIV_CELLS'(aomc) + DIV_CELLS'(cl.side.k >> 1);
			xneg_p1 <= sn[47];
			yneg_p1 <= omc[47];
			snn_p1 <= sn[47];
			snp_p1 <= !sn[47] && sn != '0;
			csn_p1 <= cs[47];
		end
	end

	// post 2: multiplications
	logic        v_p2;
	side_t       sd_p2;
	logic [DIV_CELLS-1:0] nx_p2;
	logic [DIV_CELLS-1:0] ny_p2;
	logic        xneg_p2;
	logic        yneg_p2;
	logic        n1x_p2;
	logic        n1y_p2;
	logic        snp_p2;
	logic        csn_p2;
	logic [63:0] m1x_p2;
	logic [63:0] m1y_p2;
	logic [63:0] xa_p2;
	logic [63:0] xb_p2;
	logic [63:0] xc_p2;
	logic [63:0] ya_p2;
	logic [63:0] yb_p2;
	logic [63:0] yc_p2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_p2 <= 1'b0;
		else if (en) v_p2 <= v_p1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd_p2 <= sd_p1;
			nx_p2 <= nx_p1;
			ny_p2 <= ny_p1;
			xneg_p2 <= xneg_p1;
			yneg_p2 <= yneg_p1;
			n1x_p2 <= sd_p1.d[31] ^ csn_p1;
			n1y_p2 <= sd_p1.d[31] ^ snn_p1;
			snp_p2 <= snp_p1;
			csn_p2 <= csn_p1;
			m1x_p2 <= 64'(sd_p1.ad) * 64'(c30_p1);
			m1y_p2 <= 64'(sd_p1.ad) * 64'(s30_p1);
			xa_p2 <= 64'(sd_p1.kdd[31:0]) * 64'(s30_p1);
			xb_p2 <= 64'(sd_p1.kdd[63:32]) * 64'(s30_p1);
			xc_p2 <= 64'(sd_p1.kdd[95:64]) * 64'(s30_p1);
			ya_p2 <= 64'(sd_p1.kdd[31:0]) * 64'(c30_p1);
			yb_p2 <= 64'(sd_p1.kdd[63:32]) * 64'(c30_p1);
			yc_p2 <= 64'(sd_p1.kdd[95:64]) * 64'(c30_p1);
		end
	end

	// post 3: first derivative, second derivative magnitudes
	logic         v_p3;
	pass_t        ps_p3;
	logic [DIV_CELLS-1:0] nx_p3;
	logic [DIV_CELLS-1:0] ny_p3;
	logic         snp_p3;
	logic         csn_p3;
	logic [127:0] m2x_p3;
	logic [127:0] m2y_p3;
	logic [48:0]  r1x;
	logic [48:0]  r1y;

	assign r1x = rnd_sat(128'(m1x_p2), 30, n1x_p2);
	assign r1y = rnd_sat(128'(m1y_p2), 30, n1y_p2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_p3 <= 1'b0;
		else if (en) v_p3 <= v_p2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ps_p3.ord <= sd_p2.ord;
			ps_p3.line <= sd_p2.line;
			ps_p3.line_x <= sd_p2.line_x;
			ps_p3.d <= sd_p2.d;
			ps_p3.k <= sd_p2.k;
			ps_p3.cx1 <= $signed(r1x[47:0]);
			ps_p3.cy1 <= $signed(r1y[47:0]);
			ps_p3.sat1 <= r1x[48] | r1y[48];
			ps_p3.cx2 <= '0;
			ps_p3.cy2 <= '0;
			ps_p3.sat2 <= 1'b0;
			ps_p3.xneg <= xneg_p2;
			ps_p3.yneg <= yneg_p2;
			nx_p3 <= nx_p2;
			ny_p3 <= ny_p2;
			snp_p3 <= snp_p2;
			csn_p3 <= csn_p2;
			m2x_p3 <= 128'(xa_p2) + (128'(xb_p2) << 32) + (128'(xc_p2) << 64);
			m2y_p3 <= 128'(ya_p2) + (128'(yb_p2) << 32) + (128'(yc_p2) << 64);
		end
	end

	// post 4: second derivative rounding, into divider chain
	dv_t         dv_c;
	dv_t         dv_d [0:DIV_CELLS];
	logic        dv_v [0:DIV_CELLS];
	logic [48:0] r2x;
	logic [48:0] r2y;

	assign r2x = rnd_sat(m2x_p3, 70, snp_p3);
	assign r2y = rnd_sat(m2y_p3, 70, csn_p3);

	always_comb begin
		dv_c.rx = '0;
		dv_c.ry = '0;
		dv_c.nx = nx_p3;
		dv_c.ny = ny_p3;
		dv_c.qx = '0;
		dv_c.qy = '0;
		dv_c.p = ps_p3;
		dv_c.p.cx2 = $signed(r2x[47:0]);
		dv_c.p.cy2 = $signed(r2y[47:0]);
		dv_c.p.sat2 = r2x[48] | r2y[48];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dv_v[0] <= 1'b0;
		else if (en) dv_v[0] <= v_p3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_d[0] <= dv_c;
		end
	end

	for (genvar j = 0; j < DIV_CELLS; j++) begin : g_div
		cae_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.in_v   (dv_v[j]),
			.in_d   (dv_d[j]),
			.out_v  (dv_v[j+1]),
			.out_d  (dv_d[j+1])
		);
	end

	// result holding register and word sequencer
	dv_t                dl;
	logic signed [47:0] qx;
	logic signed [47:0] qy;
	logic               fin_v_q;
	logic [1:0]         fin_ord_q;
	logic [1:0]         idx_q;
	logic signed [47:0] fx_q [0:2];
	logic signed [47:0] fy_q [0:2];
	logic               fs_q [0:2];

	assign dl = dv_d[DIV_CELLS];
	assign qx = $signed(48'(dl.qx));
	assign qy = $signed(48'(dl.qy));
	assign en = !fin_v_q || (result_ready && idx_q == fin_ord_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_v_q <= 1'b0;
			idx_q <= '0;
		end else if (en) begin
			fin_v_q <= dv_v[DIV_CELLS];
			idx_q <= '0;
		end else if (result_ready) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fin_ord_q <= dl.p.ord;
			if (dl.p.line) begin
				fx_q[0] <= dl.p.line_x;
				fy_q[0] <= '0;
				fx_q[1] <= 48'(dl.p.d);
				fy_q[1] <= '0;
				fx_q[2] <= '0;
				fy_q[2] <= '0;
				fs_q[1] <= 1'b0;
				fs_q[2] <= 1'b0;
			end else begin
				fx_q[0] <= dl.p.xneg ? -qx : qx;
				fy_q[0] <= dl.p.yneg ? -qy : qy;
				fx_q[1] <= dl.p.cx1;
				fy_q[1] <= dl.p.cy1;
				fx_q[2] <= dl.p.cx2;
				fy_q[2] <= dl.p.cy2;
				fs_q[1] <= dl.p.sat1;
				fs_q[2] <= dl.p.sat2;
			end
			fs_q[0] <= 1'b0;
		end
	end

	assign result_valid = fin_v_q;

	always_comb begin
		result.coord_x = fx_q[idx_q];
		result.coord_y = fy_q[idx_q];
		result.deriv_index = idx_q;
		result.last_result = idx_q == fin_ord_q;
		result.saturated = fs_q[idx_q];
		if (idx_q == 2'd3) begin
			result.coord_x = '0;
			result.coord_y = '0;
			result.saturated = 1'b0;
		end
	end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench: arc point evaluator check
// Drives parameter words through several register settings, predicts the
// point and derivative words of each one and compares every result word.
// ---------------------------------------------------------------------------
module testbench;
	import cae_pkg::*;

	localparam int STAGES    = 24;
	localparam int THRESHOLD = 168;
	localparam int LATENCY   = STAGES + 92;
	localparam int WD_LIMIT  = 4000;

	class arc_scoreboard;
		logic signed [31:0] speed;
		logic signed [31:0] curv;
		logic               expl;
		result_t            arc_q[$];
		int                 errors;

		function new();
			speed = 32'sd65536;
			curv = '0;
			expl = 1'b1;
			errors = 0;
		endfunction

		function void report(string what, longint got, longint want);
			$display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
			errors++;
		endfunction

		function longint round_clip(logic [127:0] m, int s, bit neg, inout bit sat);
			logic [127:0] v;
			logic [127:0] lim;
			v = (m + (128'd1 << (s - 1))) >> s;
			lim = neg ? (128'd1 << 47) : ((128'd1 << 47) - 128'd1);
			if (v > lim) begin
				v = lim;
				sat = 1'b1;
			end
			return neg ? -longint'(v[63:0]) : longint'(v[63:0]);
		endfunction

		function longint arctan(int i);
			longint unsigned sum;
			longint unsigned term;
			int n;
			sum = 0;
			if (i == 0) return longint'(QUARTER_PI_Q40);
			for (n = 0; i * (2 * n + 1) < 62; n++) begin
				term = (64'd1 << (62 - i * (2 * n + 1))) / longint'(2 * n + 1);
				if (n % 2 == 1) sum = sum - term;
				else sum = sum + term;
			end
			return longint'((sum + (64'd1 << 21)) >> 22);
		endfunction

		function longint div_near(longint n, longint k);
			longint unsigned q;
			q = ((n < 0 ? -n : n) + (k >>> 1)) / k;
			return n < 0 ? -longint'(q) : longint'(q);
		endfunction

		function void note_item(item_t it);
			longint t, d, k, ad, at, a, x, y, z, dx, dy, sn, cs, s30, c30;
			longint cx[3], cy[3];
			bit sat[3];
			bit flip, neg;
			logic [127:0] w;
			int ord, i, j;
			result_t r;
			t = longint'(it.param_t);
			d = longint'(speed);
			k = longint'(curv);
			ad = d < 0 ? -d : d;
			at = t < 0 ? -t : t;
			neg = (d < 0) != (t < 0);
			ord = it.deriv_order > 2 ? 2 : int'(it.deriv_order);
			if (!expl) ord = 0;
			cx = '{0, 0, 0};
			cy = '{0, 0, 0};
			sat = '{0, 0, 0};
			if (k < THRESHOLD) begin
				cx[0] = round_clip(128'(ad) * 128'(at), 16, neg, sat[0]);
				cx[1] = d;
			end else begin
				w = (128'(k) * 128'(ad) * 128'(at)) % 128'(TWO_PI_Q56);
				if (neg && w != 0) w = 128'(TWO_PI_Q56) - w;
				a = longint'((w + 128'd32768) >> 16);
				flip = 1'b0;
				if (a > PI_Q40) a -= TWO_PI_Q40;
				if (a > HALF_PI_Q40) begin
					a -= PI_Q40;
					flip = 1'b1;
				end else if (a < -HALF_PI_Q40) begin
					a += PI_Q40;
					flip = 1'b1;
				end
				x = GAIN_Q40;
				y = 0;
				z = a;
				for (i = 0; i < STAGES; i++) begin
					dx = y >>> i;
					dy = x >>> i;
					if (z >= 0) begin
						x -= dx; y += dy; z -= arctan(i);
					end else begin
						x += dx; y -= dy; z += arctan(i);
					end
				end
				sn = flip ? -y : y;
				cs = flip ? -x : x;
				cx[0] = div_near(sn, k);
				cy[0] = div_near(longint'(ONE_Q40) - cs, k);
				s30 = ((sn < 0 ? -sn : sn) + 512) >>> 10;
				c30 = ((cs < 0 ? -cs : cs) + 512) >>> 10;
				cx[1] = round_clip(128'(ad) * 128'(c30), 30, (d < 0) != (cs < 0), sat[1]);
				cy[1] = round_clip(128'(ad) * 128'(s30), 30, (d < 0) != (sn < 0), sat[1]);
				cx[2] = round_clip(128'(k) * 128'(ad) * 128'(ad) * 128'(s30), 70,
					sn > 0, sat[2]);
				cy[2] = round_clip(128'(k) * 128'(ad) * 128'(ad) * 128'(c30), 70,
					cs < 0, sat[2]);
			end
			for (j = 0; j <= ord; j++) begin
				r.coord_x = cx[j][47:0];
				r.coord_y = cy[j][47:0];
				r.deriv_index = 2'(j);
				r.last_result = (j == ord);
				r.saturated = sat[j];
				arc_q.push_back(r);
			end
		endfunction

		function void check(result_t got);
			result_t want;
			if (arc_q.size() == 0) begin
				report("unexpected word", longint'(got.coord_x), 0);
				return;
			end
			want = arc_q.pop_front();
			if (got.coord_x !== want.coord_x)
				report("coord_x", longint'(got.coord_x), longint'(want.coord_x));
			if (got.coord_y !== want.coord_y)
				report("coord_y", longint'(got.coord_y), longint'(want.coord_y));
			if (got.deriv_index !== want.deriv_index)
				report("deriv_index", got.deriv_index, want.deriv_index);
			if (got.last_result !== want.last_result)
				report("last_result", got.last_result, want.last_result);
			if (got.saturated !== want.saturated)
				report("saturated", got.saturated, want.saturated);
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        item_valid;
	logic        item_ready;
	item_t       item;
	logic        result_valid;
	logic        result_ready;
	result_t     result;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	arc_scoreboard sb = new();
	bit idle_on = 1'b1;
	int hold_left = 0;
	int quiet = 0;

	circular_arc_point_evaluator #(
		.CORDIC_STAGES(STAGES),
		.LINE_THRESHOLD(THRESHOLD)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	always @(negedge clk) begin
		if (hold_left > 0) begin
			result_ready = 1'b0;
			hold_left--;
		end else
			result_ready = !idle_on || $urandom_range(99) >= 27;
	end

	always @(posedge clk) begin
		if (arst_n && item_valid && item_ready) sb.note_item(item);
		if (arst_n && result_valid && result_ready) sb.check(result);
		if ((item_valid && item_ready) || (result_valid && result_ready)) quiet = 0;
		else quiet++;
		if (quiet >= WD_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			REG_SPEED: sb.speed = val;
			REG_CURV: sb.curv = val;
			REG_EXPL: sb.expl = val[0];
			default: ;
		endcase
	endtask

	task automatic send_word(logic [31:0] t, logic [1:0] ord);
		while (idle_on && $urandom_range(99) < 27) @(negedge clk);
		item_valid = 1'b1;
		item.param_t = t;
		item.deriv_order = ord;
		do @(posedge clk); while (!item_ready);
		@(negedge clk);
		item_valid = 1'b0;
	endtask

	task automatic drain();
		while (sb.arc_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	task automatic send_random(int n);
		logic [31:0] t;
		repeat (n) begin
			case ($urandom_range(3))
				0: t = $urandom_range(262143);
				1: t = -$urandom_range(262143);
				default: t = $urandom;
			endcase
			send_word(t, 2'($urandom_range(3)));
		end
	endtask

	task automatic set_config(logic [31:0] s, logic [31:0] c, logic e);
		write_reg(REG_SPEED, s);
		write_reg(REG_CURV, c);
		write_reg(REG_EXPL, {31'd0, e});
	endtask

	logic [31:0] rs, rc;

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		result_ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_SPEED;
		cfg_data = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset defaults: straight line
		send_word(32'h0000_0000, 2'd2);
		send_word(32'h7FFF_FFFF, 2'd3);
		send_word(32'h8000_0000, 2'd2);
		send_word(32'hFFFF_FFFF, 2'd1);
		send_word(32'h0001_0000, 2'd0);
		drain();

		set_config(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
		send_word(32'h0000_0000, 2'd2);
		send_word(32'h7FFF_FFFF, 2'd2);
		send_word(32'h8000_0000, 2'd3);
		send_word(32'h0000_0001, 2'd1);
		send_random(20);
		drain();

		set_config(32'h8000_0000, 32'd167, 1'b1);
		send_word(32'h7FFF_FFFF, 2'd2);
		send_word(32'hFFFF_0000, 2'd1);
		drain();

		set_config(32'hFFFF_8000, 32'd168, 1'b1);
		send_word(32'h0003_0000, 2'd2);
		send_word(32'hFFFD_0000, 2'd2);
		send_random(10);
		drain();

		set_config(32'h0002_0000, 32'h8000_0000, 1'b0);
		send_word(32'h0005_0000, 2'd2);
		send_random(10);
		drain();

		// full rate with a long receiver stall, more words than the chain holds
		set_config(32'h0001_8000, 32'h0100_0000, 1'b1);
		idle_on = 1'b0;
		hold_left = 300;
		send_random(140);
		idle_on = 1'b1;
		drain();

		repeat (10) begin
			case ($urandom_range(3))
				0: rs = $urandom;
				1: rs = $urandom_range(32'h0004_0000);
				2: rs = -$urandom_range(32'h0004_0000);
				default: rs = {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
			endcase
			case ($urandom_range(4))
				0: rc = $urandom;
				1: rc = $urandom_range(300);
				2: rc = -$urandom_range(300);
				default: rc = $urandom_range(32'h0400_0000);
			endcase
			set_config(rs, rc, $urandom_range(99) < 80);
			send_random(16);
			drain();
		end

		if (sb.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule

>>> files.f
src/cae_pkg.sv
src/cae_red_cell.sv
src/cae_cordic_cell.sv
src/cae_div_cell.sv
src/circular_arc_point_evaluator.sv
tb/testbench.sv
